FILE: hdl/plht_pkg.sv
// ============================================================================
// plht_pkg: shared definitions for the pinned LRU handle table
// Table geometry, command and status codes, channel payloads and the
// control/status bundles between the controller and the datapath.
// ============================================================================
package plht_pkg;

    // Table geometry. The slot field of the channels is four bits wide,
    // so the table holds at most sixteen entries.
    localparam int ENTRIES    = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TREE_N     = 2 ** IDX_W;
    localparam int LEVELS     = IDX_W;
    localparam int CNT_W      = $clog2(LEVELS + 1);
    localparam int STAMP_BITS = 32;

    // Fixed field widths of the channels.
    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;
    localparam int WHENCE_W = 2;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PROBE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEEK    = 3'd4;

    // Seek bases.
    localparam logic [WHENCE_W-1:0] WHENCE_SET = 2'd0;
    localparam logic [WHENCE_W-1:0] WHENCE_CUR = 2'd1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT_PINNED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FILLED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FILL_FAIL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE       = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [31:0]         key;
        logic                auto_release;
        logic [31:0]         object_size;
        logic                fill_ok;
        logic [SLOT_W-1:0]   slot_in;
        logic signed [31:0]  seek_amount;
        logic [WHENCE_W-1:0] whence;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [31:0]         size_out;
        logic signed [31:0]  position;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic load;    // capture a request and start the lookup
        logic step;    // one level of the oldest-entry reduction
        logic commit;  // apply the command and register its result
    } t_ctrl_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_open;
    } t_dp_status;

endpackage

FILE: hdl/plht_req_if.sv
// ============================================================================
// plht_req_if: request channel
// Valid/ready channel carrying one table command per transaction.
// ============================================================================
interface plht_req_if
    import plht_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/plht_rsp_if.sv
// ============================================================================
// plht_rsp_if: response channel
// Valid/ready channel carrying one command result per transaction.
// ============================================================================
interface plht_rsp_if
    import plht_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/plht_ctrl.sv
// ============================================================================
// plht_ctrl: command sequencer
// Accepts a request, runs the oldest-entry reduction for open commands,
// then commits the command once the result register can take it.
// ============================================================================
module plht_ctrl
    import plht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // Only an open needs the victim; other commands go straight on.
                if (!i_status.is_open) begin
                    n_state = S_EXEC;
                end else begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(LEVELS - 1)) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/plht_datapath.sv
// ============================================================================
// plht_datapath: handle table storage and command execution
// Holds the entries, matches keys in parallel, reduces the unpinned stamps
// to the oldest entry one level per step, and applies committed commands.
// ============================================================================
module plht_datapath
    import plht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  t_req       i_req,
    output t_dp_status o_status,
    output t_rsp       o_rsp
);

    // Entry state.
    logic                  r_valid  [ENTRIES];
    logic                  r_pinned [ENTRIES];
    logic [STAMP_BITS-1:0] r_stamp  [ENTRIES];
    logic [31:0]           r_key    [ENTRIES];
    logic [31:0]           r_size   [ENTRIES];
    logic [31:0]           r_pos    [ENTRIES];
    logic [STAMP_BITS-1:0] r_clock;

    // Captured request and lookup results.
    t_req             r_req;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;

    // Reduction candidates.
    logic                  r_cand_ok    [TREE_N];
    logic [IDX_W-1:0]      r_cand_idx   [TREE_N];
    logic [STAMP_BITS-1:0] r_cand_stamp [TREE_N];

    t_rsp r_rsp, n_rsp;

    logic             n_hit;
    logic [IDX_W-1:0] n_hit_idx;

    logic                  vok;
    logic [IDX_W-1:0]      vidx;
    logic [IDX_W-1:0]      sidx;
    logic                  slot_ok;
    logic [STAMP_BITS-1:0] clk_next;
    logic [31:0]           seek_pos;

    // Key match against every valid entry; the lowest index wins.
    always_comb begin
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_req.key)) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
        end
    end

    assign vok      = r_cand_ok[0];
    assign vidx     = r_cand_idx[0];
    assign sidx     = r_req.slot_in[IDX_W-1:0];
    assign slot_ok  = (int'(r_req.slot_in) < ENTRIES);
    assign clk_next = r_clock + STAMP_BITS'(1);

    always_comb begin
        if (r_req.whence == WHENCE_SET) begin
            seek_pos = r_req.seek_amount;
        end else if (r_req.whence == WHENCE_CUR) begin
            seek_pos = r_pos[sidx] + r_req.seek_amount;
        end else begin
            seek_pos = r_size[sidx] + r_req.seek_amount;
        end
    end

    // Result of the captured command.
    always_comb begin
        n_rsp        = '0;
        n_rsp.status = ST_NOT_FOUND;
        unique case (r_req.cmd)
            CMD_OPEN: begin
                if (r_hit) begin
                    n_rsp.status   = r_pinned[r_hit_idx] ? ST_HIT_PINNED : ST_HIT;
                    n_rsp.slot_out = SLOT_W'(r_hit_idx);
                    n_rsp.size_out = r_size[r_hit_idx];
                end else if (!vok) begin
                    n_rsp.status = ST_NONE_FREE;
                end else if (!r_req.fill_ok) begin
                    n_rsp.status   = ST_FILL_FAIL;
                    n_rsp.slot_out = SLOT_W'(vidx);
                end else begin
                    n_rsp.status   = r_valid[vidx] ? ST_REPLACED : ST_FILLED;
                    n_rsp.slot_out = SLOT_W'(vidx);
                    n_rsp.size_out = r_req.object_size;
                end
            end
            CMD_RELEASE: begin
                if (slot_ok) begin
                    n_rsp.status   = ST_DONE;
                    n_rsp.slot_out = r_req.slot_in;
                end
            end
            CMD_FLUSH: begin
                n_rsp.status = ST_DONE;
            end
            CMD_PROBE: begin
                if (r_hit) begin
                    n_rsp.status   = ST_HIT;
                    n_rsp.slot_out = SLOT_W'(r_hit_idx);
                    n_rsp.size_out = r_size[r_hit_idx];
                end
            end
            CMD_SEEK: begin
                if (slot_ok) begin
                    n_rsp.status   = ST_DONE;
                    n_rsp.slot_out = r_req.slot_in;
                    n_rsp.position = seek_pos;
                end
            end
            default: begin
                n_rsp.status = ST_NOT_FOUND;
            end
        endcase
    end

    // Entry flags, stamps and the use clock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i]  <= 1'b0;
                r_pinned[i] <= 1'b0;
                r_stamp[i]  <= '0;
            end
            r_clock <= '0;
        end else if (i_cmd.commit) begin
            unique case (r_req.cmd)
                CMD_OPEN: begin
                    r_clock <= clk_next;
                    if (r_hit) begin
                        if (!r_pinned[r_hit_idx]) begin
                            if (r_req.auto_release) begin
                                r_stamp[r_hit_idx] <= clk_next;
                            end else begin
                                r_pinned[r_hit_idx] <= 1'b1;
                            end
                        end
                    end else if (vok) begin
                        if (!r_req.fill_ok) begin
                            r_valid[vidx]  <= 1'b0;
                            r_pinned[vidx] <= 1'b0;
                        end else begin
                            r_valid[vidx] <= 1'b1;
                            if (r_req.auto_release) begin
                                r_pinned[vidx] <= 1'b0;
                                r_stamp[vidx]  <= clk_next;
                            end else begin
                                r_pinned[vidx] <= 1'b1;
                            end
                        end
                    end
                end
                CMD_RELEASE: begin
                    if (slot_ok) begin
                        r_pinned[sidx] <= 1'b0;
                        r_stamp[sidx]  <= STAMP_BITS'(1);
                    end
                end
                CMD_FLUSH: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!r_pinned[i]) begin
                            r_valid[i] <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Entry payload, request capture, reduction and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_hit     <= n_hit;
            r_hit_idx <= n_hit_idx;
            for (int i = 0; i < TREE_N; i++) begin
                if (i < ENTRIES) begin
                    r_cand_ok[i]    <= !r_pinned[i];
                    r_cand_stamp[i] <= r_stamp[i];
                end else begin
                    r_cand_ok[i]    <= 1'b0;
                    r_cand_stamp[i] <= '0;
                end
                r_cand_idx[i] <= IDX_W'(i);
            end
        end

        // Pairwise reduction: the left candidate wins ties, which keeps the
        // lowest index among equal stamps.
        if (i_cmd.step) begin
            for (int i = 0; i < TREE_N / 2; i++) begin
                if (!r_cand_ok[2*i] ||
                    (r_cand_ok[2*i+1] && (r_cand_stamp[2*i+1] < r_cand_stamp[2*i]))) begin
                    r_cand_ok[i]    <= r_cand_ok[2*i+1];
                    r_cand_idx[i]   <= r_cand_idx[2*i+1];
                    r_cand_stamp[i] <= r_cand_stamp[2*i+1];
                end else begin
                    r_cand_ok[i]    <= r_cand_ok[2*i];
                    r_cand_idx[i]   <= r_cand_idx[2*i];
                    r_cand_stamp[i] <= r_cand_stamp[2*i];
                end
            end
            for (int i = TREE_N / 2; i < TREE_N; i++) begin
                r_cand_ok[i] <= 1'b0;
            end
        end

        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
            unique case (r_req.cmd)
                CMD_OPEN: begin
                    if (r_hit) begin
                        r_pos[r_hit_idx] <= '0;
                    end else if (vok && r_req.fill_ok) begin
                        r_key[vidx]  <= r_req.key;
                        r_size[vidx] <= r_req.object_size;
                        r_pos[vidx]  <= '0;
                    end
                end
                CMD_SEEK: begin
                    if (slot_ok) begin
                        r_pos[sidx] <= seek_pos;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.is_open = (r_req.cmd == CMD_OPEN);
    assign o_rsp            = r_rsp;

endmodule

FILE: hdl/pinned_lru_handle_table.sv
// ============================================================================
// pinned_lru_handle_table: fully associative handle table with LRU and pins
// Sixteen-entry table of object handles with timestamp replacement, pinning,
// flush, size probe and offset seek.
//
//   Channel  Dir  Handshake          Payload
//   i_req    in   valid/ready        cmd, key, auto_release, object_size,
//                                    fill_ok, slot_in, seek_amount, whence
//   o_rsp    out  valid/ready        status, slot_out, size_out, position
//
// The accepting edge captures a request and matches its key. An open then
// steps through every level of the oldest-stamp reduction before the command
// is committed to the result register; other commands skip the reduction and
// go from acceptance through the search state to the commit. A new request is
// taken only after the previous one is committed; the result register lets it
// be accepted while the previous result waits. A stalled result register holds
// the commit step. Reset is synchronous and clears the valid, pin and stamp
// state at once.
// ============================================================================
module pinned_lru_handle_table
    import plht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    plht_req_if.sink   i_req,
    plht_rsp_if.source o_rsp
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;
    logic       in_ready;
    logic       out_valid;
    t_rsp       rsp_data;

    plht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd)
    );

    plht_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ctrl_cmd),
        .i_req    (i_req.data),
        .o_status (dp_status),
        .o_rsp    (rsp_data)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp_data;

`ifndef ASSERT_OFF
    // One request at a time: an accepted transaction closes the input.
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while a command is in progress");

    // A commit never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.commit |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register overwritten");

    // The reduction only runs for an open command.
    a_step_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.step |-> dp_status.is_open)
        else $error("reduction step outside an open");

    // A result appears only after a commit.
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !$past(o_rsp.valid && !o_rsp.ready)) |-> $past(ctrl_cmd.commit))
        else $error("result valid without a commit");
`endif

endmodule

FILE: bench/tb_pinned_lru_handle_table.sv
// ============================================================================
// tb_pinned_lru_handle_table: self-checking bench for the pinned LRU table
// Sends a short directed script and then random table commands through the
// request channel. A behavioral copy of the table predicts every result that the
// script does not fix, and each result is compared field by field under random stalls.
// ============================================================================
module tb_pinned_lru_handle_table;
    import plht_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ITEM  = 500;
    localparam int STORM_AT_ITEM = 200;
    localparam int PAUSE_AT_ITEM = 1100;
    localparam int KEY_POOL      = 24;

    localparam logic [CMD_W-1:0]    CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]    CMD_UNUSED_LAST  = 3'd7;
    localparam logic [WHENCE_W-1:0] WHENCE_END       = 2'd2;
    localparam logic [WHENCE_W-1:0] WHENCE_END_ALIAS = 2'd3;

    typedef struct packed {
        t_req cmd_in;
        logic typed;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    plht_req_if req_if ();
    plht_rsp_if rsp_if ();

    pinned_lru_handle_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Behavioral copy of the table. Two-state storage starts at the reset state.
    bit                  tbl_valid  [ENTRIES];
    bit                  tbl_pinned [ENTRIES];
    bit [31:0]           tbl_key    [ENTRIES];
    bit [STAMP_BITS-1:0] tbl_stamp  [ENTRIES];
    bit [31:0]           tbl_size   [ENTRIES];
    bit [31:0]           tbl_pos    [ENTRIES];
    bit                  size_known [ENTRIES];
    bit                  pos_known  [ENTRIES];
    bit [STAMP_BITS-1:0] use_count;

    t_rsp        pending_rsp[$];
    t_row        script[$];
    logic [31:0] key_pool[KEY_POOL];
    int          mismatches  = 0;
    int          issued      = 0;
    int          idle_cycles = 0;
    bit          hold_rsp    = 1'b0;

    function automatic int find_handle(input logic [31:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == key) return i;
        return -1;
    endfunction

    function automatic t_rsp table_step(input t_req r);
        t_rsp res;
        int   hit;
        int   victim;
        int   s;
        res = '0;
        s   = int'(r.slot_in);
        case (r.cmd)
            CMD_OPEN: begin
                use_count = use_count + 1'b1;
                hit = find_handle(r.key);
                if (hit >= 0) begin
                    res.status = ST_HIT;
                    if (tbl_pinned[hit]) res.status = ST_HIT_PINNED;
                    else if (r.auto_release) tbl_stamp[hit] = use_count;
                    else tbl_pinned[hit] = 1'b1;
                    tbl_pos[hit]   = '0;
                    pos_known[hit] = 1'b1;
                    res.slot_out   = SLOT_W'(hit);
                    res.size_out   = tbl_size[hit];
                end else begin
                    // Oldest unpinned entry; ties go to the lowest index.
                    victim = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!tbl_pinned[i] && (victim < 0 || tbl_stamp[i] < tbl_stamp[victim]))
                            victim = i;
                    if (victim < 0) begin
                        res.status = ST_NONE_FREE;
                    end else if (!r.fill_ok) begin
                        tbl_valid[victim]  = 1'b0;
                        tbl_pinned[victim] = 1'b0;
                        res.status   = ST_FILL_FAIL;
                        res.slot_out = SLOT_W'(victim);
                    end else begin
                        res.status = tbl_valid[victim] ? ST_REPLACED : ST_FILLED;
                        tbl_valid[victim]  = 1'b1;
                        tbl_key[victim]    = r.key;
                        tbl_size[victim]   = r.object_size;
                        tbl_pos[victim]    = '0;
                        size_known[victim] = 1'b1;
                        pos_known[victim]  = 1'b1;
                        tbl_pinned[victim] = !r.auto_release;
                        if (r.auto_release) tbl_stamp[victim] = use_count;
                        res.slot_out = SLOT_W'(victim);
                        res.size_out = r.object_size;
                    end
                end
            end
            CMD_RELEASE: begin
                if (s >= ENTRIES) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    tbl_pinned[s] = 1'b0;
                    tbl_stamp[s]  = STAMP_BITS'(1);
                    res.status    = ST_DONE;
                    res.slot_out  = r.slot_in;
                end
            end
            CMD_FLUSH: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (!tbl_pinned[i]) tbl_valid[i] = 1'b0;
                res.status = ST_DONE;
            end
            CMD_PROBE: begin
                hit = find_handle(r.key);
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.status   = ST_HIT;
                    res.slot_out = SLOT_W'(hit);
                    res.size_out = tbl_size[hit];
                end
            end
            CMD_SEEK: begin
                if (s >= ENTRIES) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    case (r.whence)
                        WHENCE_SET: tbl_pos[s] = r.seek_amount;
                        WHENCE_CUR: tbl_pos[s] = tbl_pos[s] + r.seek_amount;
                        default:    tbl_pos[s] = tbl_size[s] + r.seek_amount;
                    endcase
                    pos_known[s] = 1'b1;
                    res.status   = ST_DONE;
                    res.slot_out = r.slot_in;
                    res.position = tbl_pos[s];
                end
            end
            default: res.status = ST_NOT_FOUND;
        endcase
        return res;
    endfunction

    function automatic int idle_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_req req_of(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                                    input logic ar, input logic [31:0] osize,
                                    input logic ok, input logic [SLOT_W-1:0] slot,
                                    input logic [31:0] amount,
                                    input logic [WHENCE_W-1:0] wh);
        t_req r;
        r.cmd          = cmd;
        r.key          = key;
        r.auto_release = ar;
        r.object_size  = osize;
        r.fill_ok      = ok;
        r.slot_in      = slot;
        r.seek_amount  = amount;
        r.whence       = wh;
        return r;
    endfunction

    function automatic t_rsp rsp_of(input logic [STATUS_W-1:0] st,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic [31:0] size, input logic [31:0] pos);
        t_rsp r;
        r.status   = st;
        r.slot_out = slot;
        r.size_out = size;
        r.position = pos;
        return r;
    endfunction

    task automatic add_row(input t_req r, input logic typed, input t_rsp rsp);
        t_row row;
        row.cmd_in = r;
        row.typed  = typed;
        row.rsp    = rsp;
        script.push_back(row);
    endtask

    function automatic t_req random_command();
        t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.key = (pick < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)] : $urandom;
        r.auto_release = ($urandom_range(0, 99) >= 15);
        pick = $urandom_range(0, 99);
        if (pick < 10)      r.object_size = '0;
        else if (pick < 20) r.object_size = '1;
        else                r.object_size = $urandom;
        r.fill_ok     = ($urandom_range(0, 99) >= 8);
        r.slot_in     = SLOT_W'($urandom_range(0, ENTRIES - 1));
        r.seek_amount = $urandom;
        r.whence      = WHENCE_W'($urandom_range(WHENCE_END_ALIAS, WHENCE_SET));
        pick = $urandom_range(0, 99);
        if (pick < 52)      r.cmd = CMD_OPEN;
        else if (pick < 64) r.cmd = CMD_RELEASE;
        else if (pick < 66) r.cmd = CMD_FLUSH;
        else if (pick < 78) r.cmd = CMD_PROBE;
        else if (pick < 96) r.cmd = CMD_SEEK;
        else r.cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
        // A seek only reads the size or offset of an entry that has been written.
        if (r.cmd == CMD_SEEK) begin
            if (!size_known[r.slot_in] && r.whence >= WHENCE_END) r.whence = WHENCE_CUR;
            if (!pos_known[r.slot_in] && r.whence == WHENCE_CUR) r.whence = WHENCE_SET;
        end
        return r;
    endfunction

    // Offers one command, waits for the transaction and records its result.
    task automatic issue(input t_req r, input logic typed, input t_rsp fixed);
        int   gap;
        t_rsp predicted;
        gap = idle_gap(((issued / 128) % 4) == 1);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = table_step(r);
        pending_rsp.push_back(typed ? fixed : predicted);
        issued++;
        if (issued == HOLD_AT_ITEM) hold_rsp = 1'b1;
    endtask

    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (pending_rsp.size() == 0) begin
            $error("result with no command outstanding: status %0d slot %0d",
                   got.status, got.slot_out);
            mismatches++;
        end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.slot_out !== want.slot_out) begin
                $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
                mismatches++;
            end
            if (got.size_out !== want.size_out) begin
                $error("size_out: expected %h, got %h", want.size_out, got.size_out);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %h, got %h", want.position, got.position);
                mismatches++;
            end
        end
    endtask

    // Response side: random stalls, one long hold-off on request.
    initial begin
        int  stall;
        int  cycles;
        logic accepted;
        stall  = 0;
        cycles = 0;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cycles++;
            accepted = rsp_if.valid && rsp_if.ready;
            if (accepted) check_result(rsp_if.data);
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                stall    = HOLD_CYCLES;
            end else if (accepted) begin
                stall = idle_gap(((cycles / 200) % 5) == 3);
            end
            if (stall > 0) begin
                stall--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("FAIL pinned_lru_handle_table");
        $finish;
    end

    initial begin
        t_req item;
        t_req burst_q[$];
        int   sent;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        i_rst_n      <= 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < KEY_POOL; k++) key_pool[k] = $urandom;

        add_row(req_of(CMD_PROBE, '0, 1'b0, '0, 1'b0, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_NOT_FOUND, '0, '0, '0));
        add_row(req_of(CMD_OPEN, '1, 1'b1, '1, 1'b1, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_FILLED, 4'd0, '1, '0));
        add_row(req_of(CMD_OPEN, '0, 1'b1, '0, 1'b1, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_FILLED, 4'd1, '0, '0));
        add_row(req_of(CMD_OPEN, '1, 1'b1, '0, 1'b1, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_HIT, 4'd0, '1, '0));
        // Hit with auto release off pins the entry; the next open sees it pinned.
        add_row(req_of(CMD_OPEN, '0, 1'b0, '0, 1'b1, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_HIT, 4'd1, '0, '0));
        add_row(req_of(CMD_OPEN, '0, 1'b1, '0, 1'b1, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_HIT_PINNED, 4'd1, '0, '0));
        add_row(req_of(CMD_SEEK, '0, 1'b0, '0, 1'b0, 4'd0, 32'h7FFF_FFFF, WHENCE_SET), 1'b1,
                rsp_of(ST_DONE, 4'd0, '0, 32'h7FFF_FFFF));
        add_row(req_of(CMD_SEEK, '0, 1'b0, '0, 1'b0, 4'd0, 32'h1, WHENCE_CUR), 1'b1,
                rsp_of(ST_DONE, 4'd0, '0, 32'h8000_0000));
        add_row(req_of(CMD_SEEK, '0, 1'b0, '0, 1'b0, 4'd0, '1, WHENCE_END), 1'b1,
                rsp_of(ST_DONE, 4'd0, '0, 32'hFFFF_FFFE));
        add_row(req_of(CMD_SEEK, '0, 1'b0, '0, 1'b0, 4'd0, 32'h8000_0000, WHENCE_END_ALIAS),
                1'b1, rsp_of(ST_DONE, 4'd0, '0, 32'h7FFF_FFFF));
        add_row(req_of(CMD_PROBE, '1, 1'b0, '0, 1'b0, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_HIT, 4'd0, '1, '0));
        // Failed mapping on the oldest unpinned entry, which is still empty.
        add_row(req_of(CMD_OPEN, 32'h1234_5678, 1'b1, 32'h55, 1'b0, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_FILL_FAIL, 4'd2, '0, '0));
        add_row(req_of(CMD_OPEN, 32'hA5A5_A5A5, 1'b1, 32'h5A5A_5A5A, 1'b1, '0, '0, WHENCE_SET),
                1'b0, '0);
        add_row(req_of(CMD_RELEASE, '0, 1'b0, '0, 1'b0, 4'd1, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_DONE, 4'd1, '0, '0));
        add_row(req_of(CMD_FLUSH, '0, 1'b0, '0, 1'b0, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_DONE, '0, '0, '0));
        add_row(req_of(CMD_PROBE, '0, 1'b0, '0, 1'b0, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_NOT_FOUND, '0, '0, '0));
        add_row(req_of(CMD_SEEK, '0, 1'b0, '0, 1'b0, 4'd15, 32'h8000_0000, WHENCE_SET), 1'b1,
                rsp_of(ST_DONE, 4'd15, '0, 32'h8000_0000));
        add_row(req_of(CMD_RELEASE, '0, 1'b0, '0, 1'b0, 4'd15, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_DONE, 4'd15, '0, '0));
        add_row(req_of(CMD_UNUSED_FIRST, '1, 1'b1, '1, 1'b1, '1, '1, WHENCE_END_ALIAS), 1'b1,
                rsp_of(ST_NOT_FOUND, '0, '0, '0));
        add_row(req_of(CMD_UNUSED_LAST, '0, 1'b0, '0, 1'b0, '0, '0, WHENCE_SET), 1'b1,
                rsp_of(ST_NOT_FOUND, '0, '0, '0));
        add_row(req_of(CMD_OPEN, '1, 1'b0, 32'h1, 1'b1, '0, '0, WHENCE_SET), 1'b0, '0);
        add_row(req_of(CMD_PROBE, '1, 1'b0, '0, 1'b0, '0, '0, WHENCE_SET), 1'b0, '0);
        add_row(req_of(CMD_SEEK, '0, 1'b0, '0, 1'b0, 4'd2, 32'h0000_0100, WHENCE_CUR), 1'b0,
                '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n]) issue(script[n].cmd_in, script[n].typed, script[n].rsp);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Pin storm: more pinned opens than entries, then release every slot.
            if (burst_q.size() == 0 && (sent == STORM_AT_ITEM || $urandom_range(0, 199) == 0))
            begin
                for (int k = 0; k < ENTRIES + 2; k++) begin
                    item = random_command();
                    item.cmd          = CMD_OPEN;
                    item.key          = $urandom;
                    item.auto_release = 1'b0;
                    item.fill_ok      = 1'b1;
                    burst_q.push_back(item);
                end
                for (int k = 0; k < ENTRIES; k++) begin
                    item = random_command();
                    item.cmd     = CMD_RELEASE;
                    item.slot_in = SLOT_W'(k);
                    burst_q.push_back(item);
                end
            end
            if (sent == PAUSE_AT_ITEM) begin
                req_if.valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge i_clk);
            end
            if (burst_q.size() != 0) item = burst_q.pop_front();
            else item = random_command();
            issue(item, 1'b0, '0);
            sent++;
        end

        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS pinned_lru_handle_table");
        else
            $display("FAIL pinned_lru_handle_table");
        $finish;
    end

endmodule
